### hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SATURATION = 2'd0,
		REG_BRIGHTNESS = 2'd1
	} cfg_reg_t;

	// Width of the configuration index port.
	localparam int unsigned CFG_INDEX_BITS = 2;

	// Whole degrees of hue need nine bits (below 512).
	localparam int unsigned DEG_BITS = 9;

	// One sector spans 60 degrees; 60 needs six bits.
	localparam int unsigned SECTOR_DEG      = 60;
	localparam int unsigned SECTOR_DEG_BITS = 6;
	localparam int unsigned NUM_SECTORS     = 6;

	// Sector number (0 to 8 for any nine-bit degree value).
	localparam int unsigned SECTOR_BITS = 4;
	typedef logic [SECTOR_BITS-1:0] sector_t;

	// Degrees divided by 60: (deg * 17) >> 10 is low by at most one.
	localparam int unsigned SEC_RECIP       = 17;
	localparam int unsigned SEC_RECIP_BITS  = 5;
	localparam int unsigned SEC_RECIP_SHIFT = 10;

	// Ramp divided by 15: (v * 69905) >> 20 is low by at most one.
	localparam int unsigned DIV15_SHIFT_IN  = 2;
	localparam int unsigned DIV15           = 15;
	localparam int unsigned DIV15_BITS      = 4;
	localparam int unsigned RECIP15         = 69905;
	localparam int unsigned RECIP15_BITS    = 17;
	localparam int unsigned RECIP15_SHIFT   = 20;

	// Configuration reset values before truncation to the channel width.
	localparam int unsigned SATURATION_RESET = 179;
	localparam int unsigned BRIGHTNESS_RESET = 255;

endpackage

### hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter: one hue in, one RGB color out.
// Throughput is one hue per cycle; busy stays low, so start is never refused.
// Results are shown for one cycle and cannot be stalled by the receiver.
// Asynchronous active-low reset clears the stage valid bits and loads the default
// saturation and brightness.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
#(
	parameter int CHANNEL_BITS  = 8,
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [DEG_BITS+HUE_FRAC_BITS-1:0]     hue,
	output logic                                  done,
	output logic [CHANNEL_BITS-1:0]               red,
	output logic [CHANNEL_BITS-1:0]               green,
	output logic [CHANNEL_BITS-1:0]               blue,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
	input  logic [CHANNEL_BITS-1:0]               cfg_data
);

	localparam int N   = CHANNEL_BITS;
	localparam int HW  = DEG_BITS + HUE_FRAC_BITS;
	localparam int SW  = SECTOR_DEG_BITS + HUE_FRAC_BITS;
	localparam int VW  = N + DIV15_BITS;
	localparam int SPW = DEG_BITS + SEC_RECIP_BITS;
	localparam int LATENCY = 6;

	localparam logic [N-1:0]  FS        = {N{1'b1}};
	localparam logic [SW-1:0] SECTOR_W  = SW'(SECTOR_DEG << HUE_FRAC_BITS);
	localparam logic [HW-1:0] LOW_MASK  = HW'((1 << HUE_FRAC_BITS) - 1);

	// Configuration registers.
	logic [N-1:0] saturation_q;
	logic [N-1:0] brightness_q;

	// Stage valid bits.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage payloads.
	logic [HW-1:0]           hue_s1;
	sector_t                 sec_est_s1;
	logic [2*N-1:0]          bs_s1;

	logic [N-1:0]            c_s2, m_s2;
	sector_t                 sec_s2;
	logic [SW-1:0]           rem_s2;

	logic [N-1:0]            c_s3, m_s3;
	sector_t                 sec_s3;
	logic [SW-1:0]           t_s3;

	logic [N-1:0]            c_s4, m_s4;
	sector_t                 sec_s4;
	logic [N+SW-1:0]         prod_s4;

	logic [N-1:0]            c_s5, m_s5;
	sector_t                 sec_s5;
	logic [VW-1:0]           v_val_s5;
	logic [N:0]              qe_s5;

	logic [N-1:0]            red_s6, green_s6, blue_s6;

	logic accept;

	// The pipeline never stalls, so a hue is taken every cycle.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saturation_q <= N'(SATURATION_RESET);
			brightness_q <= N'(BRIGHTNESS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SATURATION: saturation_q <= cfg_data;
				REG_BRIGHTNESS: brightness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: value times saturation, and a sector estimate from whole degrees.
	logic [DEG_BITS-1:0] deg_in;
	logic [SPW-1:0]      sec_prod;

	assign deg_in   = hue[HW-1 -: DEG_BITS];
	assign sec_prod = SPW'(deg_in) * SPW'(SEC_RECIP);

	always_ff @(posedge clk) begin
		hue_s1     <= hue;
		sec_est_s1 <= SECTOR_BITS'(sec_prod >> SEC_RECIP_SHIFT);
		bs_s1      <= (2*N)'(brightness_q) * (2*N)'(saturation_q);
	end

	// Stage 2: chroma by division by full scale, sector and remainder in it.
	logic [2*N-1:0]      bs_sum;
	logic [N:0]          c_est;
	logic [2*N:0]        c_est_fs;
	logic [2*N:0]        c_rem;
	logic [N-1:0]        chroma;
	logic [DEG_BITS-1:0] deg_s1;
	logic [DEG_BITS-1:0] sec_deg;
	logic [DEG_BITS-1:0] deg_rem;
	logic                sec_up;
	logic [DEG_BITS-1:0] deg_rem_c;
	logic [HW-1:0]       rem_full;

	always_comb begin
		// Estimate is never high and at most one low; one compare fixes it.
		bs_sum   = bs_s1 + (bs_s1 >> N);
		c_est    = (N+1)'(bs_sum >> N);
		c_est_fs = {c_est, {N{1'b0}}} - (2*N+1)'(c_est);
		c_rem    = (2*N+1)'(bs_s1) - c_est_fs;
		chroma   = (c_rem >= (2*N+1)'(FS)) ? N'(c_est + 1'b1) : N'(c_est);

		// Whole degrees minus sector start; one step corrects the estimate.
		deg_s1    = hue_s1[HW-1 -: DEG_BITS];
		sec_deg   = DEG_BITS'(sec_est_s1) * DEG_BITS'(SECTOR_DEG);
		deg_rem   = deg_s1 - sec_deg;
		sec_up    = (deg_rem >= DEG_BITS'(SECTOR_DEG));
		deg_rem_c = sec_up ? (deg_rem - DEG_BITS'(SECTOR_DEG)) : deg_rem;
		rem_full  = (HW'(deg_rem_c) << HUE_FRAC_BITS) | (hue_s1 & LOW_MASK);
	end

	always_ff @(posedge clk) begin
		c_s2   <= chroma;
		m_s2   <= brightness_q - chroma;
		sec_s2 <= sec_up ? sector_t'(sec_est_s1 + 1'b1) : sec_est_s1;
		rem_s2 <= SW'(rem_full);
	end

	// Stage 3: rising ramp in even sectors, falling ramp in odd ones.
	always_ff @(posedge clk) begin
		c_s3   <= c_s2;
		m_s3   <= m_s2;
		sec_s3 <= sec_s2;
		t_s3   <= sec_s2[0] ? (SECTOR_W - rem_s2) : rem_s2;
	end

	// Stage 4: chroma times ramp position.
	always_ff @(posedge clk) begin
		c_s4    <= c_s3;
		m_s4    <= m_s3;
		sec_s4  <= sec_s3;
		prod_s4 <= (N+SW)'(c_s3) * (N+SW)'(t_s3);
	end

	// Stage 5: divide by the sector width as a shift by 4 << frac, then by 15
	// through a reciprocal multiply.
	logic [VW-1:0]              v_val;
	logic [VW+RECIP15_BITS-1:0] v_recip;

	assign v_val   = VW'(prod_s4 >> (HUE_FRAC_BITS + DIV15_SHIFT_IN));
	assign v_recip = (VW+RECIP15_BITS)'(v_val) * (VW+RECIP15_BITS)'(RECIP15);

	always_ff @(posedge clk) begin
		c_s5     <= c_s4;
		m_s5     <= m_s4;
		sec_s5   <= sec_s4;
		v_val_s5 <= v_val;
		qe_s5    <= (N+1)'(v_recip >> RECIP15_SHIFT);
	end

	// Stage 6: correct the quotient, place channels by sector, add the floor.
	logic [VW-1:0] qe_15;
	logic [VW-1:0] q_rem;
	logic [N-1:0]  x_val;
	logic [N-1:0]  r_c, g_c, b_c;

	always_comb begin
		qe_15 = (VW'(qe_s5) << DIV15_BITS) - VW'(qe_s5);
		q_rem = v_val_s5 - qe_15;
		x_val = (q_rem >= VW'(DIV15)) ? N'(qe_s5 + 1'b1) : N'(qe_s5);

		r_c = '0;
		g_c = '0;
		b_c = '0;
		case (sec_s5)
			4'd0: begin
				r_c = c_s5;
				g_c = x_val;
			end
			4'd1: begin
				r_c = x_val;
				g_c = c_s5;
			end
			4'd2: begin
				g_c = c_s5;
				b_c = x_val;
			end
			4'd3: begin
				g_c = x_val;
				b_c = c_s5;
			end
			4'd4: begin
				r_c = x_val;
				b_c = c_s5;
			end
			4'd5: begin
				r_c = c_s5;
				b_c = x_val;
			end
			// Hue at or past a full turn gives grey.
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		red_s6   <= r_c + m_s5;
		green_s6 <= g_c + m_s5;
		blue_s6  <= b_c + m_s5;
	end

	assign done  = v_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// Every done strobe comes from a hue taken exactly the latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s1, LATENCY - 1))
		else $error("done without a matching accepted hue");

	// Corrected chroma never exceeds the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (c_s2 <= brightness_q))
		else $error("chroma above brightness");

	// Remainder stays inside one sector.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_s2 < SECTOR_W))
		else $error("sector remainder out of range");

	// No channel goes past the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red <= brightness_q && green <= brightness_q && blue <= brightness_q))
		else $error("channel above brightness");

	// Inside the circle one channel carries the full value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(sec_s5) < SECTOR_BITS'(NUM_SECTORS))) |->
		(red == brightness_q || green == brightness_q || blue == brightness_q))
		else $error("no channel at full value");

endmodule

### tb/sv/hsv_to_rgb_converter_tb.sv
module hsv_to_rgb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_BITS      = DEG_BITS + HUE_FRAC_BITS;
	localparam int FULL_SCALE    = (1 << CHANNEL_BITS) - 1;
	localparam int SECTOR_SPAN   = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int HUE_TOP       = NUM_SECTORS * SECTOR_SPAN - 1;
	localparam int HUE_MAX       = (1 << HUE_BITS) - 1;
	localparam int NUM_REGS      = 2;
	localparam int PHASE_HUES    = 150;
	localparam int DRAIN_CYCLES  = 12;
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_PRINTS    = 30;

	localparam logic [CHANNEL_BITS-1:0] CH_FULL = CHANNEL_BITS'(FULL_SCALE);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_t;

	// Expected colors in flight, plus the register copy used to predict them.
	class color_tracker;
		rgb_t pending_colors[$];
		logic [CHANNEL_BITS-1:0] sat_reg = SATURATION_RESET[CHANNEL_BITS-1:0];
		logic [CHANNEL_BITS-1:0] bri_reg = BRIGHTNESS_RESET[CHANNEL_BITS-1:0];
		int mismatches;
		int hues_seen;
		int grey_hues;
		int colors_checked;
		int reg_writes;

		// Six-sector HSV rule with truncating fixed-point divisions.
		function rgb_t hsv_color(logic [HUE_BITS-1:0] h);
			int unsigned chroma, sector, offset, ramp, floor_level;
			int unsigned r, g, b;
			rgb_t color;
			chroma      = (bri_reg * sat_reg) / FULL_SCALE;
			sector      = h / SECTOR_SPAN;
			offset      = h % SECTOR_SPAN;
			floor_level = bri_reg - chroma;
			if (sector % 2 == 0) begin
				ramp = (chroma * offset) / SECTOR_SPAN;
			end else begin
				ramp = (chroma * (SECTOR_SPAN - offset)) / SECTOR_SPAN;
			end
			r = 0;
			g = 0;
			b = 0;
			case (sector)
				0: begin r = chroma; g = ramp; end
				1: begin r = ramp; g = chroma; end
				2: begin g = chroma; b = ramp; end
				3: begin g = ramp; b = chroma; end
				4: begin r = ramp; b = chroma; end
				5: begin r = chroma; b = ramp; end
				// Hue at or past a full turn carries no chroma: grey.
				default: ;
			endcase
			color.red   = CHANNEL_BITS'(r + floor_level);
			color.green = CHANNEL_BITS'(g + floor_level);
			color.blue  = CHANNEL_BITS'(b + floor_level);
			return color;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CHANNEL_BITS-1:0] data);
			reg_writes++;
			case (idx)
				REG_SATURATION: sat_reg = data;
				REG_BRIGHTNESS: bri_reg = data;
				// Unknown indexes leave both registers alone.
				default: ;
			endcase
		endfunction

		function void note_hue(logic [HUE_BITS-1:0] h);
			hues_seen++;
			if (h > HUE_TOP) grey_hues++;
			pending_colors.insert(pending_colors.size(), hsv_color(h));
		endfunction

		task report_mismatch(string what, int got, int want);
			mismatches++;
			if (mismatches <= MAX_PRINTS) begin
				$display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
			end
		endtask

		task check_color(rgb_t got);
			rgb_t want;
			colors_checked++;
			if (pending_colors.size() == 0) begin
				report_mismatch("color with no hue waiting (red)", int'(got.red), -1);
			end else begin
				want = pending_colors.pop_front();
				if (got.red !== want.red)
					report_mismatch("red", int'(got.red), int'(want.red));
				if (got.green !== want.green)
					report_mismatch("green", int'(got.green), int'(want.green));
				if (got.blue !== want.blue)
					report_mismatch("blue", int'(got.blue), int'(want.blue));
			end
		endtask

		function int pending();
			return pending_colors.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [HUE_BITS-1:0] hue = '0;
	logic done;
	logic [CHANNEL_BITS-1:0] red, green, blue;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CHANNEL_BITS-1:0] cfg_data = '0;

	color_tracker colors = new();
	int idle_pct;
	int quiet_cycles;
	int settings_run;

	hsv_to_rgb_converter #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.hue      (hue),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Observe every transfer at the clock edge, on values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) colors.check_color({red, green, blue});
			if (start && !busy) colors.note_hue(hue);
			if (cfg_valid && cfg_ready) colors.write_reg(cfg_index, cfg_data);
		end
	end

	// Watchdog: end the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done || (start && !busy) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog expired after %0d quiet cycles", quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Offer one hue and hold it until the transfer. Before it, each cycle stays
	// idle with a chance of idle_pct percent, so that share of cycles is idle.
	task send_hue(logic [HUE_BITS-1:0] h);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		hue   <= h;
		do @(posedge clk); while (busy);
	endtask

	// Stop offering hues and wait until every expected color has come out.
	// The first edge lets the monitor log a hue taken at the current edge.
	task drain_colors();
		start <= 1'b0;
		@(posedge clk);
		while (colors.pending() != 0) @(posedge clk);
	endtask

	// One register write; valid is lowered by the caller after the last one.
	task write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CHANNEL_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load a new saturation and brightness, sometimes with a stray unknown index.
	task load_setting(logic [CHANNEL_BITS-1:0] sat, logic [CHANNEL_BITS-1:0] bri);
		logic [CFG_INDEX_BITS-1:0] stray;
		drain_colors();
		if ($urandom_range(1)) begin
			write_reg(REG_SATURATION, sat);
			write_reg(REG_BRIGHTNESS, bri);
		end else begin
			write_reg(REG_BRIGHTNESS, bri);
			write_reg(REG_SATURATION, sat);
		end
		if ($urandom_range(99) < 40) begin
			stray = CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1, NUM_REGS));
			write_reg(stray, CHANNEL_BITS'($urandom));
		end
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	// Mostly in-range hues, some near sector edges, some past a full turn.
	function logic [HUE_BITS-1:0] random_hue();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return HUE_BITS'($urandom_range(HUE_TOP, 0));
		if (pick < 85) begin
			return HUE_BITS'($urandom_range(NUM_SECTORS - 1, 0) * SECTOR_SPAN
				+ $urandom_range(2, 0) - 1 + SECTOR_SPAN * $urandom_range(1, 0));
		end
		return HUE_BITS'($urandom_range(HUE_MAX, HUE_TOP + 1));
	endfunction

	initial begin
		logic [CHANNEL_BITS-1:0] sat_list[8];
		logic [CHANNEL_BITS-1:0] bri_list[8];
		int k;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sector edges, last valid hue, grey hues, reset registers.
		idle_pct = 0;
		send_hue(HUE_BITS'(0));
		send_hue(HUE_BITS'(1));
		send_hue(HUE_BITS'(SECTOR_SPAN - 1));
		send_hue(HUE_BITS'(SECTOR_SPAN));
		send_hue(HUE_BITS'(SECTOR_SPAN + 1));
		send_hue(HUE_BITS'(2 * SECTOR_SPAN - 1));
		send_hue(HUE_BITS'(2 * SECTOR_SPAN));
		send_hue(HUE_BITS'(3 * SECTOR_SPAN));
		send_hue(HUE_BITS'(4 * SECTOR_SPAN));
		send_hue(HUE_BITS'(5 * SECTOR_SPAN));
		send_hue(HUE_BITS'(HUE_TOP));
		send_hue(HUE_BITS'(HUE_TOP + 1));
		send_hue(HUE_BITS'(HUE_MAX));

		// Directed: full saturation and brightness, middle of every sector.
		load_setting(CH_FULL, CH_FULL);
		for (k = 0; k < NUM_SECTORS; k++)
			send_hue(HUE_BITS'(k * SECTOR_SPAN + SECTOR_SPAN / 2));

		// Directed: zero saturation, then zero brightness.
		load_setting('0, CH_FULL);
		send_hue(HUE_BITS'(SECTOR_SPAN / 3));
		send_hue(HUE_BITS'(HUE_MAX));
		load_setting(CH_FULL, '0);
		send_hue(HUE_BITS'(3 * SECTOR_SPAN + 7));

		// Random phases over a spread of register settings and idle rates.
		sat_list = '{CHANNEL_BITS'(SATURATION_RESET), CH_FULL, '0, CH_FULL, '0,
			CHANNEL_BITS'(128), '0, '0};
		bri_list = '{CHANNEL_BITS'(BRIGHTNESS_RESET), CH_FULL, CH_FULL, '0, '0,
			CHANNEL_BITS'(200), '0, '0};
		for (int p = 0; p < 8; p++) begin
			if (p >= 6) begin
				sat_list[p] = CHANNEL_BITS'($urandom);
				bri_list[p] = CHANNEL_BITS'($urandom);
			end
			load_setting(sat_list[p], bri_list[p]);
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 58;
				default: idle_pct = 26;
			endcase
			for (int n = 0; n < PHASE_HUES; n++) begin
				// Now and then let the pipeline run empty mid-phase.
				if (n == PHASE_HUES / 2 && $urandom_range(1)) drain_colors();
				send_hue(random_hue());
			end
		end

		drain_colors();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d hues (%0d past a full turn) under %0d register settings.",
			colors.hues_seen, colors.grey_hues, settings_run);
		$display("Checked %0d colors, %0d register writes, %0d mismatches.",
			colors.colors_checked, colors.reg_writes, colors.mismatches);
		if (colors.mismatches == 0 && colors.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### sim.f
hdl/hsv2rgb_pkg.sv
hdl/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_tb.sv
